/* hdl/cmtg_pkg.sv */
package cmtg_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int TEX_FRAC_BITS_DEF = 16;
    localparam int NORM_WIDTH        = 16;
    localparam int COORD_FRAC        = 12;
    localparam int CFG_IDX_WIDTH     = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_BOX_MAX_Z = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic [1:0] axis;
        logic       neg;
    } t_face_ctl;

endpackage

/* hdl/cube_map_texcoord_gen_unit.sv */
// throughput: one item per cycle while i_stall is low; the quotient is formed one bit per stage
// in a TEX_FRAC_BITS deep compare-subtract pipe behind three setup stages
// a stall only holds the stages that are full, bubbles close up behind it
// reset clears all valid bits and the box registers to zero
module cube_map_texcoord_gen_unit #(
    parameter int COORD_WIDTH   = cmtg_pkg::COORD_WIDTH_DEF,
    parameter int TEX_FRAC_BITS = cmtg_pkg::TEX_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [cmtg_pkg::CFG_IDX_WIDTH-1:0]     i_cfg_index,
    input  logic [COORD_WIDTH-1:0]                 i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [COORD_WIDTH-1:0]          i_point_x,
    input  logic signed [COORD_WIDTH-1:0]          i_point_y,
    input  logic signed [COORD_WIDTH-1:0]          i_point_z,
    input  logic signed [cmtg_pkg::NORM_WIDTH-1:0] i_normal_x,
    input  logic signed [cmtg_pkg::NORM_WIDTH-1:0] i_normal_y,
    input  logic signed [cmtg_pkg::NORM_WIDTH-1:0] i_normal_z,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [TEX_FRAC_BITS:0]                 o_tex_s,
    output logic [TEX_FRAC_BITS:0]                 o_tex_t
);
    import cmtg_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int F = TEX_FRAC_BITS;

    logic signed [W-1:0] r_box_min_x, r_box_min_y, r_box_min_z;
    logic signed [W-1:0] r_box_max_x, r_box_max_y, r_box_max_z;

    logic         fr_ready, fr_valid, dv_ready, dv_valid, fc_ready;
    t_face_ctl    fr_ctl, dv_ctl;
    logic [W+1:0] fr_den, fr_rem_s, fr_rem_t;
    logic         fr_zero_s, fr_sat_s, fr_zero_t, fr_sat_t;
    logic         dv_zero_s, dv_sat_s, dv_zero_t, dv_sat_t;
    logic [F-1:0] dv_quo_s, dv_quo_t;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min_x <= '0;
            r_box_min_y <= '0;
            r_box_min_z <= '0;
            r_box_max_x <= '0;
            r_box_max_y <= '0;
            r_box_max_z <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BOX_MIN_X: r_box_min_x <= i_cfg_data;
                CFG_BOX_MIN_Y: r_box_min_y <= i_cfg_data;
                CFG_BOX_MIN_Z: r_box_min_z <= i_cfg_data;
                CFG_BOX_MAX_X: r_box_max_x <= i_cfg_data;
                CFG_BOX_MAX_Y: r_box_max_y <= i_cfg_data;
                CFG_BOX_MAX_Z: r_box_max_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = !fr_ready;

    cmtg_front #(.W(W)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_min_x (r_box_min_x),
        .i_box_min_y (r_box_min_y),
        .i_box_min_z (r_box_min_z),
        .i_box_max_x (r_box_max_x),
        .i_box_max_y (r_box_max_y),
        .i_box_max_z (r_box_max_z),
        .i_valid     (i_valid),
        .o_ready     (fr_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_normal_x  (i_normal_x),
        .i_normal_y  (i_normal_y),
        .i_normal_z  (i_normal_z),
        .o_valid     (fr_valid),
        .i_ready     (dv_ready),
        .o_ctl       (fr_ctl),
        .o_den       (fr_den),
        .o_zero_s    (fr_zero_s),
        .o_sat_s     (fr_sat_s),
        .o_rem_s     (fr_rem_s),
        .o_zero_t    (fr_zero_t),
        .o_sat_t     (fr_sat_t),
        .o_rem_t     (fr_rem_t)
    );

    cmtg_div #(.W(W), .F(F)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fr_valid),
        .o_ready  (dv_ready),
        .i_ctl    (fr_ctl),
        .i_den    (fr_den),
        .i_zero_s (fr_zero_s),
        .i_sat_s  (fr_sat_s),
        .i_rem_s  (fr_rem_s),
        .i_zero_t (fr_zero_t),
        .i_sat_t  (fr_sat_t),
        .i_rem_t  (fr_rem_t),
        .o_valid  (dv_valid),
        .i_ready  (fc_ready),
        .o_ctl    (dv_ctl),
        .o_zero_s (dv_zero_s),
        .o_sat_s  (dv_sat_s),
        .o_quo_s  (dv_quo_s),
        .o_zero_t (dv_zero_t),
        .o_sat_t  (dv_sat_t),
        .o_quo_t  (dv_quo_t)
    );

    cmtg_face #(.F(F)) u_face (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dv_valid),
        .o_ready  (fc_ready),
        .i_ctl    (dv_ctl),
        .i_zero_s (dv_zero_s),
        .i_sat_s  (dv_sat_s),
        .i_quo_s  (dv_quo_s),
        .i_zero_t (dv_zero_t),
        .i_sat_t  (dv_sat_t),
        .i_quo_t  (dv_quo_t),
        .o_valid  (o_valid),
        .i_ready  (!i_stall),
        .o_tex_s  (o_tex_s),
        .o_tex_t  (o_tex_t)
    );

endmodule

/* hdl/cmtg_front.sv */
module cmtg_front #(
    parameter int W = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [W-1:0]                  i_box_min_x,
    input  logic signed [W-1:0]                  i_box_min_y,
    input  logic signed [W-1:0]                  i_box_min_z,
    input  logic signed [W-1:0]                  i_box_max_x,
    input  logic signed [W-1:0]                  i_box_max_y,
    input  logic signed [W-1:0]                  i_box_max_z,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [W-1:0]                  i_point_x,
    input  logic signed [W-1:0]                  i_point_y,
    input  logic signed [W-1:0]                  i_point_z,
    input  logic signed [cmtg_pkg::NORM_WIDTH-1:0] i_normal_x,
    input  logic signed [cmtg_pkg::NORM_WIDTH-1:0] i_normal_y,
    input  logic signed [cmtg_pkg::NORM_WIDTH-1:0] i_normal_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output cmtg_pkg::t_face_ctl                  o_ctl,
    output logic [W+1:0]                         o_den,
    output logic                                 o_zero_s,
    output logic                                 o_sat_s,
    output logic [W+1:0]                         o_rem_s,
    output logic                                 o_zero_t,
    output logic                                 o_sat_t,
    output logic [W+1:0]                         o_rem_t
);
    import cmtg_pkg::*;

    localparam logic [W:0] UNIT_SIDE = (W+1)'(1) << COORD_FRAC;

    logic signed [W:0]          diff_x, diff_y, diff_z, diff_m;
    logic [W:0]                 side;
    logic [NORM_WIDTH:0]        abs_x, abs_y, abs_z;
    logic [1:0]                 axis;
    logic signed [W-1:0]        sel_p_s, sel_lo_s, sel_hi_s, sel_p_t, sel_lo_t, sel_hi_t;
    logic                       neg;
    logic                       rdy1, rdy2, rdy3;

    // stage 1
    logic                       r1_v;
    t_face_ctl                  r1_ctl;
    logic [W:0]                 r1_side;
    logic signed [W-1:0]        r1_p_s, r1_lo_s, r1_hi_s, r1_p_t, r1_lo_t, r1_hi_t;
    // stage 2
    logic                       r2_v;
    t_face_ctl                  r2_ctl;
    logic [W+1:0]               r2_den;
    logic signed [W+2:0]        r2_num_s, r2_num_t;
    logic signed [W+2:0]        n_num_s, n_num_t;
    // stage 3
    logic                       r3_v;
    t_face_ctl                  r3_ctl;
    logic [W+1:0]               r3_den;
    logic                       r3_zero_s, r3_sat_s, r3_zero_t, r3_sat_t;
    logic [W+1:0]               r3_rem_s, r3_rem_t;

    assign rdy3    = !r3_v || i_ready;
    assign rdy2    = !r2_v || rdy3;
    assign rdy1    = !r1_v || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        diff_x = {i_box_max_x[W-1], i_box_max_x} - {i_box_min_x[W-1], i_box_min_x};
        diff_y = {i_box_max_y[W-1], i_box_max_y} - {i_box_min_y[W-1], i_box_min_y};
        diff_z = {i_box_max_z[W-1], i_box_max_z} - {i_box_min_z[W-1], i_box_min_z};
        diff_m = diff_x;
        if (diff_y > diff_m) diff_m = diff_y;
        if (diff_z > diff_m) diff_m = diff_z;
        // a box with no positive extent on any axis falls back to a unit side
        side = (diff_m <= 0) ? UNIT_SIDE : diff_m;

        abs_x = i_normal_x[NORM_WIDTH-1] ? (NORM_WIDTH+1)'(-{i_normal_x[NORM_WIDTH-1], i_normal_x})
                                         : {1'b0, i_normal_x};
        abs_y = i_normal_y[NORM_WIDTH-1] ? (NORM_WIDTH+1)'(-{i_normal_y[NORM_WIDTH-1], i_normal_y})
                                         : {1'b0, i_normal_y};
        abs_z = i_normal_z[NORM_WIDTH-1] ? (NORM_WIDTH+1)'(-{i_normal_z[NORM_WIDTH-1], i_normal_z})
                                         : {1'b0, i_normal_z};
        // ties keep the lower axis
        axis = AXIS_X;
        if (abs_y > abs_x) axis = AXIS_Y;
        if (abs_z > ((axis == AXIS_Y) ? abs_y : abs_x)) axis = AXIS_Z;

        case (axis)
            AXIS_Y: begin
                neg = i_normal_y[NORM_WIDTH-1];
                sel_p_s = i_point_z; sel_lo_s = i_box_min_z; sel_hi_s = i_box_max_z;
                sel_p_t = i_point_x; sel_lo_t = i_box_min_x; sel_hi_t = i_box_max_x;
            end
            AXIS_Z: begin
                neg = i_normal_z[NORM_WIDTH-1];
                sel_p_s = i_point_x; sel_lo_s = i_box_min_x; sel_hi_s = i_box_max_x;
                sel_p_t = i_point_y; sel_lo_t = i_box_min_y; sel_hi_t = i_box_max_y;
            end
            default: begin
                neg = i_normal_x[NORM_WIDTH-1];
                sel_p_s = i_point_y; sel_lo_s = i_box_min_y; sel_hi_s = i_box_max_y;
                sel_p_t = i_point_z; sel_lo_t = i_box_min_z; sel_hi_t = i_box_max_z;
            end
        endcase
    end

    // numerator in doubled units: 2p - lo - hi + side
    always_comb begin
        n_num_s = ((W+3)'(r1_p_s) <<< 1) - (W+3)'(r1_lo_s) - (W+3)'(r1_hi_s)
                  + $signed({2'b00, r1_side});
        n_num_t = ((W+3)'(r1_p_t) <<< 1) - (W+3)'(r1_lo_t) - (W+3)'(r1_hi_t)
                  + $signed({2'b00, r1_side});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (rdy1) r1_v <= i_valid;
            if (rdy2) r2_v <= r1_v;
            if (rdy3) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_ctl.axis <= axis;
            r1_ctl.neg  <= neg;
            r1_side     <= side;
            r1_p_s      <= sel_p_s;
            r1_lo_s     <= sel_lo_s;
            r1_hi_s     <= sel_hi_s;
            r1_p_t      <= sel_p_t;
            r1_lo_t     <= sel_lo_t;
            r1_hi_t     <= sel_hi_t;
        end
        if (rdy2 && r1_v) begin
            r2_ctl   <= r1_ctl;
            r2_den   <= {r1_side, 1'b0};
            r2_num_s <= n_num_s;
            r2_num_t <= n_num_t;
        end
        if (rdy3 && r2_v) begin
            r3_ctl    <= r2_ctl;
            r3_den    <= r2_den;
            r3_zero_s <= r2_num_s[W+2] || (r2_num_s == '0);
            r3_sat_s  <= !r2_num_s[W+2] && (r2_num_s[W+1:0] >= r2_den);
            r3_rem_s  <= r2_num_s[W+1:0];
            r3_zero_t <= r2_num_t[W+2] || (r2_num_t == '0);
            r3_sat_t  <= !r2_num_t[W+2] && (r2_num_t[W+1:0] >= r2_den);
            r3_rem_t  <= r2_num_t[W+1:0];
        end
    end

    assign o_valid  = r3_v;
    assign o_ctl    = r3_ctl;
    assign o_den    = r3_den;
    assign o_zero_s = r3_zero_s;
    assign o_sat_s  = r3_sat_s;
    assign o_rem_s  = r3_rem_s;
    assign o_zero_t = r3_zero_t;
    assign o_sat_t  = r3_sat_t;
    assign o_rem_t  = r3_rem_t;

endmodule

/* hdl/cmtg_div.sv */
module cmtg_div #(
    parameter int W = 24,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cmtg_pkg::t_face_ctl i_ctl,
    input  logic [W+1:0]        i_den,
    input  logic                i_zero_s,
    input  logic                i_sat_s,
    input  logic [W+1:0]        i_rem_s,
    input  logic                i_zero_t,
    input  logic                i_sat_t,
    input  logic [W+1:0]        i_rem_t,
    output logic                o_valid,
    input  logic                i_ready,
    output cmtg_pkg::t_face_ctl o_ctl,
    output logic                o_zero_s,
    output logic                o_sat_s,
    output logic [F-1:0]        o_quo_s,
    output logic                o_zero_t,
    output logic                o_sat_t,
    output logic [F-1:0]        o_quo_t
);
    import cmtg_pkg::*;

    logic               r_v      [F];
    t_face_ctl          r_ctl    [F];
    logic [W+1:0]       r_den    [F];
    logic               r_zero_s [F];
    logic               r_sat_s  [F];
    logic [W+1:0]       r_rem_s  [F];
    logic [F-1:0]       r_quo_s  [F];
    logic               r_zero_t [F];
    logic               r_sat_t  [F];
    logic [W+1:0]       r_rem_t  [F];
    logic [F-1:0]       r_quo_t  [F];
    logic               rdy      [F+1];

    assign rdy[F] = i_ready;

    // one quotient bit per stage, restoring form
    for (genvar k = 0; k < F; k++) begin : g_stage
        logic         p_v, p_zero_s, p_sat_s, p_zero_t, p_sat_t;
        t_face_ctl    p_ctl;
        logic [W+1:0] p_den, p_rem_s, p_rem_t;
        logic [F-1:0] p_quo_s, p_quo_t;
        logic [W+2:0] dbl_s, dbl_t;
        logic         ge_s, ge_t;

        if (k == 0) begin : g_first
            assign p_v      = i_valid;
            assign p_ctl    = i_ctl;
            assign p_den    = i_den;
            assign p_zero_s = i_zero_s;
            assign p_sat_s  = i_sat_s;
            assign p_rem_s  = i_rem_s;
            assign p_quo_s  = '0;
            assign p_zero_t = i_zero_t;
            assign p_sat_t  = i_sat_t;
            assign p_rem_t  = i_rem_t;
            assign p_quo_t  = '0;
        end else begin : g_next
            assign p_v      = r_v[k-1];
            assign p_ctl    = r_ctl[k-1];
            assign p_den    = r_den[k-1];
            assign p_zero_s = r_zero_s[k-1];
            assign p_sat_s  = r_sat_s[k-1];
            assign p_rem_s  = r_rem_s[k-1];
            assign p_quo_s  = r_quo_s[k-1];
            assign p_zero_t = r_zero_t[k-1];
            assign p_sat_t  = r_sat_t[k-1];
            assign p_rem_t  = r_rem_t[k-1];
            assign p_quo_t  = r_quo_t[k-1];
        end

        assign rdy[k] = !r_v[k] || rdy[k+1];
        assign dbl_s  = {p_rem_s, 1'b0};
        assign dbl_t  = {p_rem_t, 1'b0};
        assign ge_s   = dbl_s >= {1'b0, p_den};
        assign ge_t   = dbl_t >= {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k] && p_v) begin
                r_ctl[k]    <= p_ctl;
                r_den[k]    <= p_den;
                r_zero_s[k] <= p_zero_s;
                r_sat_s[k]  <= p_sat_s;
                r_rem_s[k]  <= ge_s ? (W+2)'(dbl_s - {1'b0, p_den}) : dbl_s[W+1:0];
                r_quo_s[k]  <= {p_quo_s[F-2:0], ge_s};
                r_zero_t[k] <= p_zero_t;
                r_sat_t[k]  <= p_sat_t;
                r_rem_t[k]  <= ge_t ? (W+2)'(dbl_t - {1'b0, p_den}) : dbl_t[W+1:0];
                r_quo_t[k]  <= {p_quo_t[F-2:0], ge_t};
            end
        end
    end

    assign o_ready  = rdy[0];
    assign o_valid  = r_v[F-1];
    assign o_ctl    = r_ctl[F-1];
    assign o_zero_s = r_zero_s[F-1];
    assign o_sat_s  = r_sat_s[F-1];
    assign o_quo_s  = r_quo_s[F-1];
    assign o_zero_t = r_zero_t[F-1];
    assign o_sat_t  = r_sat_t[F-1];
    assign o_quo_t  = r_quo_t[F-1];

endmodule

/* hdl/cmtg_face.sv */
module cmtg_face #(
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cmtg_pkg::t_face_ctl i_ctl,
    input  logic                i_zero_s,
    input  logic                i_sat_s,
    input  logic [F-1:0]        i_quo_s,
    input  logic                i_zero_t,
    input  logic                i_sat_t,
    input  logic [F-1:0]        i_quo_t,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [F:0]          o_tex_s,
    output logic [F:0]          o_tex_t
);
    import cmtg_pkg::*;

    localparam logic [F:0] TEX_ONE = (F+1)'(1) << F;

    logic [F:0] s, t, n_os, n_ot;
    logic       r_v;
    logic [F:0] r_os, r_ot;
    logic       rdy;

    assign rdy     = !r_v || i_ready;
    assign o_ready = rdy;

    always_comb begin
        s = i_zero_s ? '0 : (i_sat_s ? TEX_ONE : {1'b0, i_quo_s});
        t = i_zero_t ? '0 : (i_sat_t ? TEX_ONE : {1'b0, i_quo_t});
        case (i_ctl.axis)
            AXIS_Y: begin
                n_os = t;
                n_ot = TEX_ONE - s;
                if (i_ctl.neg) n_ot = TEX_ONE - n_ot;
            end
            AXIS_Z: begin
                n_os = s;
                n_ot = t;
                if (i_ctl.neg) n_os = TEX_ONE - n_os;
            end
            default: begin
                n_os = TEX_ONE - t;
                n_ot = s;
                if (i_ctl.neg) n_os = TEX_ONE - n_os;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_os <= n_os;
            r_ot <= n_ot;
        end
    end

    assign o_valid = r_v;
    assign o_tex_s = r_os;
    assign o_tex_t = r_ot;

endmodule
